// ===== rtl/core/lstk_pkg.sv =====
package lstk_pkg;

    localparam int unsigned DATA_W = 32;

    // Operation codes carried on the kind port
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PALI = 2'd2;
    localparam logic [1:0] KIND_DISP = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_value;
        logic                     is_palindrome;
        logic                     last;
    } t_result;

endpackage

// ===== rtl/core/lstk_mem.sv =====
module lstk_mem #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [lstk_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr_a,
    input  logic [AW-1:0]                     i_raddr_b,
    output logic signed [lstk_pkg::DATA_W-1:0] o_rdata_a,
    output logic signed [lstk_pkg::DATA_W-1:0] o_rdata_b
);

    logic signed [lstk_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/core/lstk_ctrl.sv =====
module lstk_ctrl #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [1:0]                         i_kind,
    input  logic signed [lstk_pkg::DATA_W-1:0] i_item_value,
    output logic                               busy,
    output logic                               strobe,
    output lstk_pkg::t_result                  o_res,
    // memory side
    output logic                               o_we,
    output logic [AW-1:0]                      o_waddr,
    output logic signed [lstk_pkg::DATA_W-1:0] o_wdata,
    output logic [AW-1:0]                      o_raddr_a,
    output logic [AW-1:0]                      o_raddr_b,
    input  logic signed [lstk_pkg::DATA_W-1:0] i_rdata_a,
    input  logic signed [lstk_pkg::DATA_W-1:0] i_rdata_b
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_PAL  = 2'd2;
    localparam logic [1:0] S_DISP = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic              r_eq, n_eq;
    logic              r_strobe, n_strobe;
    lstk_pkg::t_result r_res, n_res;

    logic [CW-1:0]     cm1_full;
    logic [AW-1:0]     cm1;
    logic              pair_eq;

    assign cm1_full = r_count - CW'(1);
    assign cm1      = cm1_full[AW-1:0];
    assign pair_eq  = r_eq & (i_rdata_a == i_rdata_b);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_ptr     = r_ptr;
        n_eq      = r_eq;
        n_strobe  = 1'b0;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = r_count[AW-1:0];
        o_wdata   = i_item_value;
        o_raddr_a = '0;
        o_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_kind)
                        lstk_pkg::KIND_PUSH: begin
                            n_strobe = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_res = '{lstk_pkg::ST_FULL, '0, 1'b0, 1'b1};
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                n_res   = '{lstk_pkg::ST_OK, '0, 1'b0, 1'b1};
                            end
                        end
                        lstk_pkg::KIND_POP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_res    = '{lstk_pkg::ST_EMPTY, '0, 1'b0, 1'b1};
                            end else begin
                                n_count   = cm1_full;
                                o_raddr_a = cm1;
                                n_state   = S_POP;
                            end
                        end
                        lstk_pkg::KIND_PALI: begin
                            if (r_count < CW'(2)) begin
                                n_strobe = 1'b1;
                                n_res    = '{lstk_pkg::ST_OK, '0, 1'b1, 1'b1};
                            end else begin
                                // read the outermost pair, then walk inward
                                o_raddr_a = '0;
                                o_raddr_b = cm1;
                                n_lo      = AW'(1);
                                n_hi      = cm1 - AW'(1);
                                n_eq      = 1'b1;
                                n_state   = S_PAL;
                            end
                        end
                        lstk_pkg::KIND_DISP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_res    = '{lstk_pkg::ST_EMPTY, '0, 1'b0, 1'b1};
                            end else begin
                                o_raddr_a = cm1;
                                n_ptr     = cm1;
                                n_state   = S_DISP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_strobe = 1'b1;
                n_res    = '{lstk_pkg::ST_OK, i_rdata_a, 1'b0, 1'b1};
                n_state  = S_IDLE;
            end
            S_PAL: begin
                if (r_lo < r_hi) begin
                    o_raddr_a = r_lo;
                    o_raddr_b = r_hi;
                    n_lo      = r_lo + AW'(1);
                    n_hi      = r_hi - AW'(1);
                    n_eq      = pair_eq;
                end else begin
                    n_strobe = 1'b1;
                    n_res    = '{lstk_pkg::ST_OK, '0, pair_eq, 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_DISP: begin
                // emit one entry per cycle, top down
                n_strobe = 1'b1;
                n_res    = '{lstk_pkg::ST_OK, i_rdata_a, 1'b0, (r_ptr == '0)};
                if (r_ptr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    o_raddr_a = r_ptr - AW'(1);
                    n_ptr     = r_ptr - AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_ptr <= n_ptr;
        r_eq  <= n_eq;
        r_res <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign strobe = r_strobe;
    assign o_res  = r_res;

    a_busy_ends_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (r_strobe && r_res.last))
        else $error("walk ended without a final result");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == lstk_pkg::KIND_PUSH && r_count == CW'(DEPTH))
        |=> ($stable(r_count) && r_res.status == lstk_pkg::ST_FULL))
        else $error("push on full stack changed the count");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_res.last) |-> busy)
        else $error("non-final result with no walk in progress");

endmodule

// ===== rtl/core/lifo_stack_with_palindrome_check.sv =====
// Bounded LIFO stack of signed 32-bit words with a palindrome query.
// Requests: raise start with i_kind and i_item_value; the request is taken
// at a rising edge where start is high and busy is low. Kinds: push, pop,
// palindrome query, display (all entries, top first).
// Results: each result is marked by strobe, high for a single cycle, and
// stays on o_status, o_data_value, o_is_palindrome and o_last until the
// next one; o_last flags the final result of a request. The receiver
// cannot stall, so results never wait. Push and every empty/full/short
// case answer in the next cycle and busy stays low, so such requests can
// be issued every cycle. Pop reads the memory, then answers from the
// S_POP state. A palindrome query reads one mirror pair per cycle from the
// two read ports. Display reads the top entry, then gives one result per
// cycle, top down. The single synchronous memory has a registered read;
// busy is high while a read walk is in progress.
// Reset (i_rst_n low at a clock edge) empties the stack; the memory
// contents are not cleared and only written entries are ever read.
module lifo_stack_with_palindrome_check #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [1:0]                         i_kind,
    input  logic signed [lstk_pkg::DATA_W-1:0] i_item_value,
    output logic                               busy,
    output logic                               strobe,
    output logic [1:0]                         o_status,
    output logic signed [lstk_pkg::DATA_W-1:0] o_data_value,
    output logic                               o_is_palindrome,
    output logic                               o_last
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lstk_pkg::t_result                  res;
    logic                               we;
    logic [AW-1:0]                      waddr;
    logic signed [lstk_pkg::DATA_W-1:0] wdata;
    logic [AW-1:0]                      raddr_a;
    logic [AW-1:0]                      raddr_b;
    logic signed [lstk_pkg::DATA_W-1:0] rdata_a;
    logic signed [lstk_pkg::DATA_W-1:0] rdata_b;

    lstk_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_kind       (i_kind),
        .i_item_value (i_item_value),
        .busy         (busy),
        .strobe       (strobe),
        .o_res        (res),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr_a    (raddr_a),
        .o_raddr_b    (raddr_b),
        .i_rdata_a    (rdata_a),
        .i_rdata_b    (rdata_b)
    );

    lstk_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign o_status        = res.status;
    assign o_data_value    = res.data_value;
    assign o_is_palindrome = res.is_palindrome;
    assign o_last          = res.last;

endmodule
